@@ rtl/bft_pkg.sv @@
// ----------------------------------------------------------------------------
// bft_pkg
// Shared widths, codes and transaction types of the bigram frequency table.
// ----------------------------------------------------------------------------
package bft_pkg;

   localparam int CAPACITY_DEF = 256;

   localparam int OP_W     = 3;
   localparam int KEY_W    = 16;
   localparam int FREQ_W   = 31;
   localparam int POS_W    = 8;
   localparam int SLOT_W   = 8;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = OP_W;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = STATUS_W + 1;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
   localparam logic [OP_W-1:0] OP_FIND  = 3'd1;
   localparam logic [OP_W-1:0] OP_READ  = 3'd2;
   localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

   typedef enum logic [2:0] {
      KIND_ADD,
      KIND_FIND,
      KIND_READ,
      KIND_WRITE,
      KIND_CLEAR,
      KIND_NOP
   } bft_kind_type;

   typedef struct packed {
      bft_kind_type        kind;
      logic [KEY_W-1:0]    key;
      logic [FREQ_W-1:0]   freq;
      logic [POS_W-1:0]    pos;
   } bft_cmd_type;

   typedef struct packed {
      logic                appended;
      logic [STATUS_W-1:0] status;
      logic [FREQ_W-1:0]   freq;
      logic [KEY_W-1:0]    key;
      logic [SLOT_W-1:0]   slot;
   } bft_rsp_type;

   typedef struct packed {
      logic empty;
      logic full;
   } bft_fifo_status_type;

endpackage

@@ rtl/bft_front.sv @@
// ----------------------------------------------------------------------------
// bft_front
// Input side: takes request transactions and turns the op code into a
// command kind for the back end queue.
// ----------------------------------------------------------------------------
module bft_front
   import bft_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // key[15:0], freq[46:16], position[54:47]
   input  logic [REQ_USER_W-1:0] req_tuser,   // op[2:0]
   input  bft_fifo_status_type   fifo_stat,
   output logic                  push,
   output bft_cmd_type           cmd
);

   bft_kind_type kind;

   always_comb begin
      case (req_tuser)
         OP_ADD:   kind = KIND_ADD;
         OP_FIND:  kind = KIND_FIND;
         OP_READ:  kind = KIND_READ;
         OP_WRITE: kind = KIND_WRITE;
         OP_CLEAR: kind = KIND_CLEAR;
         default:  kind = KIND_NOP;
      endcase
   end

   assign req_tready = !fifo_stat.full;
   assign push       = req_tvalid && !fifo_stat.full;

   assign cmd.kind = kind;
   assign cmd.key  = req_tdata[15:0];
   assign cmd.freq = req_tdata[46:16];
   assign cmd.pos  = req_tdata[54:47];

endmodule

@@ rtl/bft_fifo.sv @@
// ----------------------------------------------------------------------------
// bft_fifo
// Short command queue that decouples request intake from table execution.
// ----------------------------------------------------------------------------
module bft_fifo
   import bft_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bft_cmd_type         push_data,
   input  logic                pop,
   output bft_cmd_type         head,
   output bft_fifo_status_type stat
);

   bft_cmd_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QPTR_W'(1);
   endfunction

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/bft_back.sv @@
// ----------------------------------------------------------------------------
// bft_back
// Execution side: holds the key and count memories, scans for keys one entry
// per cycle and drives the registered response.
// ----------------------------------------------------------------------------
module bft_back
   import bft_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  bft_cmd_type      head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bft_rsp_type      rsp_data,
   output logic [CNT_W-1:0] used_count
);

   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int SLOT_EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_FETCH = 5'b00100,
      S_TAKE  = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   bft_cmd_type       cmd_ff, cmd_in;
   bft_rsp_type       res_ff, res_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bft_rsp_type       rsp_data_ff, rsp_data_in;

   logic [KEY_W-1:0]  key_mem [CAPACITY];
   logic [FREQ_W-1:0] cnt_mem [CAPACITY];
   logic [KEY_W-1:0]  rd_key_ff;
   logic [FREQ_W-1:0] rd_cnt_ff;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [KEY_W-1:0]  mem_wkey;
   logic [FREQ_W-1:0] mem_wcnt;
   logic [IDX_W-1:0]  mem_raddr;

   logic [CMP_W-1:0]  head_pos_ext, cmd_pos_ext, used_ext;
   logic              head_pos_ok;
   logic [FREQ_W:0]   sum_wide;
   logic [FREQ_W-1:0] sum_sat;
   logic              hit, miss;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] i);
      logic [SLOT_EXT_W-1:0] e;
      e = SLOT_EXT_W'(i);
      return e[SLOT_W-1:0];
   endfunction

   assign head_pos_ext = CMP_W'(head.pos);
   assign cmd_pos_ext  = CMP_W'(cmd_ff.pos);
   assign used_ext     = CMP_W'(used_ff);
   assign head_pos_ok  = head_pos_ext < used_ext;

   assign sum_wide = {1'b0, rd_cnt_ff} + {1'b0, cmd_ff.freq};
   assign sum_sat  = sum_wide[FREQ_W] ? FREQ_MAX : sum_wide[FREQ_W-1:0];

   assign hit  = cmp_valid_ff && (rd_key_ff == cmd_ff.key);
   assign miss = !cmp_valid_ff && (issue_ff == used_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      res_in       = res_ff;
      used_in      = used_ff;
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = issue_ff[IDX_W-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wkey     = cmd_ff.key;
      mem_wcnt     = cmd_ff.freq;
      mem_raddr    = '0;

      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               cmd_in   = head;
               issue_in = '0;
               res_in   = '0;
               state_in = S_EMIT;
               case (head.kind)
                  KIND_ADD, KIND_FIND: begin
                     state_in = S_SCAN;
                  end
                  KIND_READ: begin
                     if (head_pos_ok) begin
                        state_in = S_FETCH;
                     end else begin
                        res_in.slot   = head.pos;
                        res_in.status = ST_BAD_POS;
                     end
                  end
                  KIND_WRITE: begin
                     res_in.slot = head.pos;
                     if (head_pos_ok) begin
                        mem_we      = 1'b1;
                        mem_waddr   = head_pos_ext[IDX_W-1:0];
                        mem_wkey    = head.key;
                        mem_wcnt    = head.freq;
                        res_in.key  = head.key;
                        res_in.freq = head.freq;
                     end else begin
                        res_in.status = ST_BAD_POS;
                     end
                  end
                  KIND_CLEAR: begin
                     used_in = '0;
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // keep one read in flight, compare the entry read last cycle
            if (issue_ff < used_ff) begin
               mem_raddr    = issue_ff[IDX_W-1:0];
               cmp_valid_in = 1'b1;
               issue_in     = issue_ff + CNT_W'(1);
            end
            res_in = '0;
            if (hit) begin
               state_in    = S_EMIT;
               res_in.slot = slot_of(cmp_idx_ff);
               res_in.key  = rd_key_ff;
               if (cmd_ff.kind == KIND_ADD) begin
                  mem_we      = 1'b1;
                  mem_waddr   = cmp_idx_ff;
                  mem_wkey    = rd_key_ff;
                  mem_wcnt    = sum_sat;
                  res_in.freq = sum_sat;
               end else begin
                  res_in.freq = rd_cnt_ff;
               end
            end else if (miss) begin
               state_in   = S_EMIT;
               res_in.key = cmd_ff.key;
               if (cmd_ff.kind == KIND_ADD) begin
                  if (used_ff < CNT_W'(CAPACITY)) begin
                     mem_we          = 1'b1;
                     mem_waddr       = used_ff[IDX_W-1:0];
                     used_in         = used_ff + CNT_W'(1);
                     res_in.slot     = slot_of(used_ff[IDX_W-1:0]);
                     res_in.freq     = cmd_ff.freq;
                     res_in.appended = 1'b1;
                  end else begin
                     res_in.status = ST_FULL;
                  end
               end else begin
                  res_in.status = ST_NOT_FOUND;
               end
            end
         end

         S_FETCH: begin
            mem_raddr = cmd_pos_ext[IDX_W-1:0];
            state_in  = S_TAKE;
         end

         S_TAKE: begin
            res_in      = '0;
            res_in.slot = cmd_ff.pos;
            res_in.key  = rd_key_ff;
            res_in.freq = rd_cnt_ff;
            state_in    = S_EMIT;
         end

         S_EMIT: begin
            // hold until the response register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      res_ff      <= res_in;
      issue_ff    <= issue_in;
      cmp_idx_ff  <= cmp_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= mem_wkey;
         cnt_mem[mem_waddr] <= mem_wcnt;
      end
      rd_key_ff <= key_mem[mem_raddr];
      rd_cnt_ff <= cnt_mem[mem_raddr];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign used_count = used_ff;

endmodule

@@ rtl/bigram_frequency_table.sv @@
// From dispatch to response: add and find scan the used entries one per cycle until a
// hit or the end of the used entries; a valid read passes through the fetch and take
// states; write, clear, bad position and spare op go straight to the emit state.
// The back end works on one command at a time; a two-entry command queue accepts
// requests while the back end works, until it is full. Reset (synchronous, active
// high) empties the table, the queue and the response register.
// ----------------------------------------------------------------------------
// bigram_frequency_table
// Bounded bigram key table with saturating frequency counts, linear search.
// ----------------------------------------------------------------------------
module bigram_frequency_table
   import bft_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // key[15:0], freq[46:16], position[54:47]
   input  logic [REQ_USER_W-1:0] req_tuser,   // op[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // slot[7:0], key_out[23:8], freq_out[54:24]
   output logic [RSP_USER_W-1:0] rsp_tuser    // status[1:0], appended[2]
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   bft_fifo_status_type fifo_stat;
   bft_cmd_type         push_cmd;
   bft_cmd_type         head;
   bft_rsp_type         rsp_data;
   logic                push, pop;
   logic [CNT_W-1:0]    used_count;

   bft_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fifo_stat  (fifo_stat),
      .push       (push),
      .cmd        (push_cmd)
   );

   bft_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .head      (head),
      .stat      (fifo_stat)
   );

   bft_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!fifo_stat.empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_data),
      .used_count (used_count)
   );

   assign rsp_tdata = {1'b0, rsp_data.freq, rsp_data.key, rsp_data.slot};
   assign rsp_tuser = {rsp_data.appended, rsp_data.status};

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_stat.empty)
      else $error("command popped from empty queue");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_stat.full)
      else $error("command pushed into full queue");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_count <= CNT_W'(CAPACITY))
      else $error("used entry count exceeds capacity");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (used_count == '0))
      else $error("table not empty after reset");

endmodule
